FILE: rtl/pcorr_pkg.sv
package pcorr_pkg;

   localparam int SAMPLE_BITS     = 16;
   localparam int DEF_MAX_SAMPLES = 4096;

   typedef struct packed {
      logic accumulate;
      logic clear;
   } acc_ctl_type;

endpackage

FILE: rtl/pearson_correlation.sv
// Pearson correlation of paired signed samples. Pairs are taken one beat per cycle while
// a set is being gathered; the beat marked last_pair closes the set and the block then
// stalls its input while one shared wide adder works through the final arithmetic:
// shift-add products for the two variances and the covariance numerator, the squared
// numerator, the variance product and a bit-by-bit square root. After the closing beat the
// block starts, runs its shift-add steps, takes the absolute value, makes its adder passes
// for each result bit and posts the result. A set that overflowed skips the arithmetic, a
// set with a flat series skips all that follows the covariance numerator, and a previous
// result still held by a stalled response delays the post until it drains. The result is
// r in Q1.15, truncated toward zero and saturated to +/-32767, with status 0 valid, 1 flat
// series, 2 too many pairs; the sums clear when the result is posted.
module pearson_correlation #(
   parameter int MAX_SAMPLES = pcorr_pkg::DEF_MAX_SAMPLES
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [pcorr_pkg::SAMPLE_BITS-1:0] req_sample_a,
   input  logic signed [pcorr_pkg::SAMPLE_BITS-1:0] req_sample_b,
   input  logic                                     req_last_pair,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [pcorr_pkg::SAMPLE_BITS-1:0] rsp_correlation,
   output logic        [1:0]                        rsp_status
);
   import pcorr_pkg::*;

   localparam int LOG_W    = $clog2(MAX_SAMPLES);
   localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W    = SAMPLE_BITS + LOG_W;
   localparam int SAB_W    = 2 * SAMPLE_BITS + LOG_W;
   localparam int SQ_W     = 2 * SAMPLE_BITS - 1 + LOG_W;
   localparam int DX_W     = 2 * SAMPLE_BITS - 1 + 2 * LOG_W;
   localparam int W        = 2 * DX_W + 2 * SAMPLE_BITS;
   localparam int QW       = SAMPLE_BITS;
   localparam int SQ_SHIFT = 2 * (SAMPLE_BITS - 1);
   localparam int CW       = $clog2(DX_W + 1);

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FLAT     = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_START = 4'd1;
   localparam logic [3:0] S_DX1   = 4'd2;
   localparam logic [3:0] S_DX2   = 4'd3;
   localparam logic [3:0] S_DY1   = 4'd4;
   localparam logic [3:0] S_DY2   = 4'd5;
   localparam logic [3:0] S_NUM1  = 4'd6;
   localparam logic [3:0] S_NUM2  = 4'd7;
   localparam logic [3:0] S_ABS   = 4'd8;
   localparam logic [3:0] S_RHS   = 4'd9;
   localparam logic [3:0] S_DD    = 4'd10;
   localparam logic [3:0] S_SQA   = 4'd11;
   localparam logic [3:0] S_SQB   = 4'd12;
   localparam logic [3:0] S_SQC   = 4'd13;
   localparam logic [3:0] S_SQD   = 4'd14;
   localparam logic [3:0] S_DONE  = 4'd15;

   acc_ctl_type             acc_ctl;
   logic        [CNT_W-1:0] count;
   logic signed [SUM_W-1:0] sum_a;
   logic signed [SUM_W-1:0] sum_b;
   logic signed [SAB_W-1:0] sum_ab;
   logic        [SQ_W-1:0]  sum_aa;
   logic        [SQ_W-1:0]  sum_bb;
   logic                    overflow;
   logic        [SUM_W-1:0] mag_a;
   logic        [SUM_W-1:0] mag_b;

   logic [3:0]        state_ff, state_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [W-1:0]      acc_ff, acc_in;
   logic [W-1:0]      mcand_ff, mcand_in;
   logic [DX_W-1:0]   mult_ff, mult_in;
   logic              sub_ff, sub_in;
   logic [W-1:0]      p_ff, p_in;
   logic [W-1:0]      qs_ff, qs_in;
   logic [W-1:0]      rhs_ff, rhs_in;
   logic [DX_W-1:0]   dx_ff, dx_in;
   logic [DX_W-1:0]   dy_ff, dy_in;
   logic [QW-1:0]     q_ff, q_in;
   logic              neg_ff, neg_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [QW-1:0]     rsp_corr_ff, rsp_corr_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   logic [W-1:0]      add_a;
   logic [W-1:0]      add_b;
   logic              add_sub;
   logic [W:0]        add_sum;
   logic              load_go;
   logic [QW-1:0]     q_sat;

   pcorr_accum #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_accum (
      .clock    (clock),
      .reset    (reset),
      .ctl      (acc_ctl),
      .sample_a (req_sample_a),
      .sample_b (req_sample_b),
      .count    (count),
      .sum_a    (sum_a),
      .sum_b    (sum_b),
      .sum_ab   (sum_ab),
      .sum_aa   (sum_aa),
      .sum_bb   (sum_bb),
      .overflow (overflow)
   );

   assign mag_a = sum_a[SUM_W-1] ? $unsigned(-sum_a) : $unsigned(sum_a);
   assign mag_b = sum_b[SUM_W-1] ? $unsigned(-sum_b) : $unsigned(sum_b);

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      add_a   = acc_ff;
      add_b   = mcand_ff;
      add_sub = sub_ff;
      unique case (state_ff)
         S_ABS: begin
            add_a   = '0;
            add_b   = acc_ff;
            add_sub = neg_ff;
         end
         S_SQA: begin
            add_a   = p_ff;
            add_b   = qs_ff;
            add_sub = 1'b0;
         end
         S_SQB: begin
            add_a   = acc_ff;
            add_b   = mcand_ff;
            add_sub = 1'b0;
         end
         S_SQC: begin
            add_a   = rhs_ff;
            add_b   = acc_ff;
            add_sub = 1'b1;
         end
         S_SQD: begin
            add_a   = qs_ff;
            add_b   = {mcand_ff[W-2:0], 1'b0};
            add_sub = 1'b0;
         end
         default: begin
            add_a   = acc_ff;
            add_b   = mcand_ff;
            add_sub = sub_ff;
         end
      endcase
   end

   assign add_sum = {1'b0, add_a} + {1'b0, add_sub ? ~add_b : add_b} + (W + 1)'(add_sub);

   assign q_sat = q_ff[QW-1] ? {1'b0, {(QW - 1){1'b1}}} : q_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      mcand_in      = mcand_ff;
      mult_in       = mult_ff;
      sub_in        = sub_ff;
      p_in          = p_ff;
      qs_in         = qs_ff;
      rhs_in        = rhs_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      q_in          = q_ff;
      neg_in        = neg_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_corr_in   = rsp_corr_ff;
      rsp_status_in = rsp_status_ff;
      acc_ctl       = '0;
      load_go       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               acc_ctl.accumulate = 1'b1;
               if (req_last_pair) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            q_in   = '0;
            neg_in = 1'b0;
            if (overflow) begin
               res_status_in = STATUS_OVERFLOW;
               state_in      = S_DONE;
            end else begin
               res_status_in = STATUS_OK;
               state_in      = S_DX1;
               load_go       = 1'b1;
            end
         end
         S_DX1, S_DX2, S_DY1, S_DY2, S_NUM1, S_NUM2, S_RHS, S_DD: begin
            if (mult_ff[0]) begin
               acc_in = add_sum[W-1:0];
            end
            mcand_in = {mcand_ff[W-2:0], 1'b0};
            mult_in  = {1'b0, mult_ff[DX_W-1:1]};
            cnt_in   = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               unique case (state_ff)
                  S_DX1: begin
                     state_in = S_DX2;
                     load_go  = 1'b1;
                  end
                  S_DX2: begin
                     dx_in    = acc_in[DX_W-1:0];
                     state_in = S_DY1;
                     load_go  = 1'b1;
                  end
                  S_DY1: begin
                     state_in = S_DY2;
                     load_go  = 1'b1;
                  end
                  S_DY2: begin
                     dy_in    = acc_in[DX_W-1:0];
                     state_in = S_NUM1;
                     load_go  = 1'b1;
                  end
                  S_NUM1: begin
                     state_in = S_NUM2;
                     load_go  = 1'b1;
                  end
                  S_NUM2: begin
                     if (dx_ff == '0 || dy_ff == '0) begin
                        res_status_in = STATUS_FLAT;
                        state_in      = S_DONE;
                     end else begin
                        neg_in   = acc_in[W-1];
                        state_in = S_ABS;
                     end
                  end
                  S_RHS: begin
                     rhs_in   = acc_in;
                     state_in = S_DD;
                     load_go  = 1'b1;
                  end
                  default: begin
                     mcand_in = acc_in << SQ_SHIFT;
                     p_in     = '0;
                     qs_in    = '0;
                     cnt_in   = CW'(QW);
                     state_in = S_SQA;
                  end
               endcase
            end
         end
         S_ABS: begin
            mult_in  = add_sum[DX_W-1:0];
            mcand_in = W'(add_sum[DX_W-1:0]) << SQ_SHIFT;
            acc_in   = '0;
            sub_in   = 1'b0;
            cnt_in   = CW'(DX_W);
            state_in = S_RHS;
         end
         S_SQA: begin
            acc_in   = add_sum[W-1:0];
            state_in = S_SQB;
         end
         S_SQB: begin
            acc_in   = add_sum[W-1:0];
            state_in = S_SQC;
         end
         S_SQC: begin
            if (add_sum[W]) begin
               p_in     = acc_ff;
               q_in     = q_ff | (QW'(1) << (cnt_ff - CW'(1)));
               state_in = S_SQD;
            end else begin
               qs_in    = {1'b0, qs_ff[W-1:1]};
               mcand_in = {2'b00, mcand_ff[W-1:2]};
               cnt_in   = cnt_ff - CW'(1);
               state_in = (cnt_ff == CW'(1)) ? S_DONE : S_SQA;
            end
         end
         S_SQD: begin
            qs_in    = add_sum[W:1];
            mcand_in = {2'b00, mcand_ff[W-1:2]};
            cnt_in   = cnt_ff - CW'(1);
            state_in = (cnt_ff == CW'(1)) ? S_DONE : S_SQA;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_corr_in   = neg_ff ? (QW'(0) - q_sat) : q_sat;
               rsp_status_in = res_status_ff;
               acc_ctl.clear = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (load_go) begin
         unique case (state_in)
            S_DX1: begin
               mcand_in = W'(sum_aa);
               mult_in  = DX_W'(count);
               cnt_in   = CW'(CNT_W);
               sub_in   = 1'b0;
               acc_in   = '0;
            end
            S_DX2: begin
               mcand_in = W'(sum_a);
               mult_in  = DX_W'(mag_a);
               cnt_in   = CW'(SUM_W);
               sub_in   = !sum_a[SUM_W-1];
            end
            S_DY1: begin
               mcand_in = W'(sum_bb);
               mult_in  = DX_W'(count);
               cnt_in   = CW'(CNT_W);
               sub_in   = 1'b0;
               acc_in   = '0;
            end
            S_DY2: begin
               mcand_in = W'(sum_b);
               mult_in  = DX_W'(mag_b);
               cnt_in   = CW'(SUM_W);
               sub_in   = !sum_b[SUM_W-1];
            end
            S_NUM1: begin
               mcand_in = W'(sum_ab);
               mult_in  = DX_W'(count);
               cnt_in   = CW'(CNT_W);
               sub_in   = 1'b0;
               acc_in   = '0;
            end
            S_NUM2: begin
               mcand_in = W'(sum_a);
               mult_in  = DX_W'(mag_b);
               cnt_in   = CW'(SUM_W);
               sub_in   = !sum_b[SUM_W-1];
            end
            S_DD: begin
               mcand_in = W'(dx_ff);
               mult_in  = dy_ff;
               cnt_in   = CW'(DX_W);
               sub_in   = 1'b0;
               acc_in   = '0;
            end
            default: begin
               mcand_in = mcand_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      acc_ff        <= acc_in;
      mcand_ff      <= mcand_in;
      mult_ff       <= mult_in;
      sub_ff        <= sub_in;
      p_ff          <= p_in;
      qs_ff         <= qs_in;
      rhs_ff        <= rhs_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      q_ff          <= q_in;
      neg_ff        <= neg_in;
      res_status_ff <= res_status_in;
      rsp_corr_ff   <= rsp_corr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_correlation = $signed(rsp_corr_ff);
   assign rsp_status      = rsp_status_ff;

endmodule

FILE: rtl/pcorr_accum.sv
module pcorr_accum #(
   parameter  int MAX_SAMPLES = pcorr_pkg::DEF_MAX_SAMPLES,
   localparam int LOG_W       = $clog2(MAX_SAMPLES),
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1),
   localparam int SUM_W       = pcorr_pkg::SAMPLE_BITS + LOG_W,
   localparam int SAB_W       = 2 * pcorr_pkg::SAMPLE_BITS + LOG_W,
   localparam int SQ_W        = 2 * pcorr_pkg::SAMPLE_BITS - 1 + LOG_W
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pcorr_pkg::acc_ctl_type                 ctl,
   input  logic signed [pcorr_pkg::SAMPLE_BITS-1:0] sample_a,
   input  logic signed [pcorr_pkg::SAMPLE_BITS-1:0] sample_b,
   output logic        [CNT_W-1:0]                count,
   output logic signed [SUM_W-1:0]                sum_a,
   output logic signed [SUM_W-1:0]                sum_b,
   output logic signed [SAB_W-1:0]                sum_ab,
   output logic        [SQ_W-1:0]                 sum_aa,
   output logic        [SQ_W-1:0]                 sum_bb,
   output logic                                   overflow
);
   import pcorr_pkg::*;

   logic        [CNT_W-1:0]           count_ff, count_in;
   logic signed [SUM_W-1:0]           sum_a_ff, sum_a_in;
   logic signed [SUM_W-1:0]           sum_b_ff, sum_b_in;
   logic signed [SAB_W-1:0]           sum_ab_ff, sum_ab_in;
   logic        [SQ_W-1:0]            sum_aa_ff, sum_aa_in;
   logic        [SQ_W-1:0]            sum_bb_ff, sum_bb_in;
   logic                              overflow_ff, overflow_in;
   logic signed [2*SAMPLE_BITS-1:0]   prod_ab;
   logic signed [2*SAMPLE_BITS-1:0]   prod_aa;
   logic signed [2*SAMPLE_BITS-1:0]   prod_bb;

   assign prod_ab = sample_a * sample_b;
   assign prod_aa = sample_a * sample_a;
   assign prod_bb = sample_b * sample_b;

   always_comb begin
      count_in    = count_ff;
      sum_a_in    = sum_a_ff;
      sum_b_in    = sum_b_ff;
      sum_ab_in   = sum_ab_ff;
      sum_aa_in   = sum_aa_ff;
      sum_bb_in   = sum_bb_ff;
      overflow_in = overflow_ff;
      if (ctl.clear) begin
         count_in    = '0;
         sum_a_in    = '0;
         sum_b_in    = '0;
         sum_ab_in   = '0;
         sum_aa_in   = '0;
         sum_bb_in   = '0;
         overflow_in = 1'b0;
      end else if (ctl.accumulate) begin
         if (count_ff == CNT_W'(MAX_SAMPLES)) begin
            overflow_in = 1'b1;
         end else begin
            count_in  = count_ff + CNT_W'(1);
            sum_a_in  = sum_a_ff + SUM_W'(sample_a);
            sum_b_in  = sum_b_ff + SUM_W'(sample_b);
            sum_ab_in = sum_ab_ff + SAB_W'(prod_ab);
            sum_aa_in = sum_aa_ff + SQ_W'(prod_aa[2*SAMPLE_BITS-2:0]);
            sum_bb_in = sum_bb_ff + SQ_W'(prod_bb[2*SAMPLE_BITS-2:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         sum_a_ff    <= '0;
         sum_b_ff    <= '0;
         sum_ab_ff   <= '0;
         sum_aa_ff   <= '0;
         sum_bb_ff   <= '0;
         overflow_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         sum_a_ff    <= sum_a_in;
         sum_b_ff    <= sum_b_in;
         sum_ab_ff   <= sum_ab_in;
         sum_aa_ff   <= sum_aa_in;
         sum_bb_ff   <= sum_bb_in;
         overflow_ff <= overflow_in;
      end
   end

   assign count    = count_ff;
   assign sum_a    = sum_a_ff;
   assign sum_b    = sum_b_ff;
   assign sum_ab   = sum_ab_ff;
   assign sum_aa   = sum_aa_ff;
   assign sum_bb   = sum_bb_ff;
   assign overflow = overflow_ff;

endmodule
